@@ rtl/mkpw_pkg.sv @@
// ----------------------------------------------------------------------------
// mkpw_pkg
// Shared types and constants for the Markov index to password generator.
// ----------------------------------------------------------------------------
package mkpw_pkg;

  // item modes
  localparam logic [1:0] MODE_GEN   = 2'd0;
  localparam logic [1:0] MODE_TABLE = 2'd1;
  localparam logic [1:0] MODE_RADIX = 2'd2;
  localparam logic [1:0] MODE_COUNT = 2'd3;

  localparam int unsigned VAL_W    = 64;
  localparam int unsigned RADIX_W  = 9;
  localparam int unsigned OUT_LIMIT = 16;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  position;
    logic [7:0]  prev_char;
    logic [3:0]  rank;
    logic [63:0] value;
  } mkpw_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [3:0] char_pos;
    logic [4:0] pass_length;
    logic       last;
    logic       out_of_range;
  } mkpw_out_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } mkpw_div_ctl_t;

  typedef struct packed {
    logic done;
  } mkpw_div_sts_t;

endpackage

@@ rtl/mkpw_div.sv @@
// ----------------------------------------------------------------------------
// mkpw_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend by a small
// radix.
// ----------------------------------------------------------------------------
module mkpw_div
  import mkpw_pkg::*;
#(
  parameter int unsigned RW = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mkpw_div_ctl_t       ctl,
  input  logic [VAL_W-1:0]    dividend,
  input  logic [RW-1:0]       divisor,
  output mkpw_div_sts_t       sts,
  output logic [VAL_W-1:0]    quotient,
  output logic [RW-1:0]       remainder
);

  logic [VAL_W-1:0] q_r, q_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [RW-1:0]    dvs_r, dvs_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [RW:0]      trial;

  // load the operands on start, else one shift-subtract step while busy
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[VAL_W-1]};
    if (ctl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = 7'(VAL_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = RW'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[RW-1:0];
        q_nxt   = {q_r[VAL_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.done  = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

@@ rtl/markov_index_to_password.sv @@
// ----------------------------------------------------------------------------
// markov_index_to_password
// Maps a global candidate index to a password through a per-position Markov
// next-character table.
// ----------------------------------------------------------------------------
// Load items (table entry, radix, cumulative count) give no result and never
// raise busy, so loads can follow each other with no gap. A generate item
// holds busy high from the accepting edge until its last strobe has gone. An
// index at or past the stop count gives one result with out_of_range set.
// Otherwise the length search compares the index with each cumulative count
// in turn, reading each count before its compare, the base is the index minus
// the count below the found length, and each position runs the shared
// bit-serial divider, reads the table with the remainder as rank, then emits.
// Each character leaves as a one-cycle out_valid strobe; the receiver cannot
// hold results off, so it must take every strobe.
// ----------------------------------------------------------------------------
module markov_index_to_password
  import mkpw_pkg::*;
#(
  parameter int unsigned MAX_LEN    = 16,
  parameter int unsigned CHARSET    = 256,
  parameter int unsigned MAX_THRESH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mkpw_in_t  in_data,
  output logic      out_valid,
  output mkpw_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int unsigned PW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW  = (CHARSET > 1) ? $clog2(CHARSET) : 1;
  localparam int unsigned TW  = (MAX_THRESH > 1) ? $clog2(MAX_THRESH) : 1;
  localparam int unsigned RW  = $clog2(MAX_THRESH + 1);
  localparam int unsigned AW  = PW + CW + TW;
  localparam int unsigned EFF = (MAX_LEN < OUT_LIMIT) ? MAX_LEN : OUT_LIMIT;
  localparam int unsigned LW  = $clog2(MAX_LEN + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_STOP  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_BASE  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_READ  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // stores
  logic [7:0]       tbl_mem [0:(1<<AW)-1];
  logic [RW-1:0]    radix_mem [0:MAX_LEN-1];
  logic [VAL_W-1:0] cnt_mem [0:MAX_LEN];
  logic [MAX_LEN:0] cnt_vld_r;

  logic [4:0]       maxl_r;
  logic [VAL_W-1:0] idx_r, idx_nxt;
  logic [VAL_W-1:0] local_r, local_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [LW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    prev_r, prev_nxt;
  logic [TW-1:0]    rk_r, rk_nxt;
  logic [VAL_W-1:0] cnt_rd_r;
  logic [LW-1:0]    cnt_addr;
  logic [RW-1:0]    radix_rd;
  logic [7:0]       tbl_rd_r;
  logic [LW-1:0]    eff_len;
  mkpw_div_ctl_t    div_ctl;
  mkpw_div_ctl_t    div_go;
  mkpw_div_sts_t    div_sts;
  logic [VAL_W-1:0] div_q;
  logic [RW-1:0]    div_rem;
  logic             div_go_r;
  logic             oor_r, oor_nxt;
  logic             rd_wait_r, rd_wait_nxt;
  logic             out_valid_r;
  mkpw_out_t        out_r;

  // effective maximum length
  always_comb begin
    eff_len = LW'(maxl_r);
    if (maxl_r == 5'd0) eff_len = LW'(1);
    if (32'(maxl_r) > EFF) eff_len = LW'(EFF);
  end

  // configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxl_r <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      maxl_r <= cfg_data;
    end
  end

  // loads into the stores
  always_ff @(posedge clk) begin
    if (start && !busy && in_data.mode == MODE_TABLE &&
        32'(in_data.position) < MAX_LEN && 32'(in_data.prev_char) < CHARSET &&
        32'(in_data.rank) < MAX_THRESH) begin
      tbl_mem[{in_data.position[PW-1:0], in_data.prev_char[CW-1:0],
               in_data.rank[TW-1:0]}] <= in_data.value[7:0];
    end
    tbl_rd_r <= tbl_mem[{pos_r[PW-1:0], prev_r, rk_r}];
  end

  always_ff @(posedge clk) begin
    if (start && !busy && in_data.mode == MODE_RADIX &&
        32'(in_data.position) < MAX_LEN) begin
      if (in_data.value == '0)
        radix_mem[in_data.position[PW-1:0]] <= RW'(1);
      else if (in_data.value > VAL_W'(MAX_THRESH))
        radix_mem[in_data.position[PW-1:0]] <= RW'(MAX_THRESH);
      else
        radix_mem[in_data.position[PW-1:0]] <= in_data.value[RW-1:0];
    end
  end
  assign radix_rd = radix_mem[pos_r[PW-1:0]];

  // cumulative counts, valid bits give the zero reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
    end else if (start && !busy && in_data.mode == MODE_COUNT &&
                 32'(in_data.position) <= MAX_LEN) begin
      cnt_vld_r[in_data.position[LW-1:0]] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (start && !busy && in_data.mode == MODE_COUNT &&
        32'(in_data.position) <= MAX_LEN) begin
      cnt_mem[in_data.position[LW-1:0]] <= in_data.value;
    end
    cnt_rd_r <= cnt_vld_r[cnt_addr] ? cnt_mem[cnt_addr] : '0;
  end

  // shared divider
  mkpw_div #(.RW(RW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_go),
    .dividend (local_r),
    .divisor  (radix_rd),
    .sts      (div_sts),
    .quotient (div_q),
    .remainder(div_rem)
  );

  // count read address
  always_comb begin
    case (state_r)
      S_IDLE:         cnt_addr = eff_len;
      S_STOP, S_SCAN: cnt_addr = len_r;
      default:        cnt_addr = len_r - LW'(1);
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    local_nxt   = local_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    prev_nxt    = prev_r;
    rk_nxt      = rk_r;
    oor_nxt     = 1'b0;
    rd_wait_nxt = 1'b0;
    div_ctl.start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start && !busy && in_data.mode == MODE_GEN) begin
          idx_nxt   = in_data.value;
          len_nxt   = LW'(1);
          state_nxt = S_STOP;
        end
      end
      S_STOP: begin
        // cnt_rd_r holds the stop count, count[1] is fetched meanwhile
        if (idx_r >= cnt_rd_r) begin
          oor_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_wait_nxt = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        // each further count: address first, then compare
        if (!rd_wait_r) begin
          rd_wait_nxt = 1'b1;
        end else if (len_r < eff_len && idx_r >= cnt_rd_r) begin
          len_nxt = len_r + LW'(1);
        end else begin
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        // cnt_rd_r holds count[len-1] once rd_wait_r is set
        if (rd_wait_r) begin
          local_nxt     = idx_r - cnt_rd_r;
          pos_nxt       = '0;
          prev_nxt      = '0;
          state_nxt     = S_DIV;
          div_ctl.start = 1'b1;
        end else begin
          rd_wait_nxt = 1'b1;
        end
      end
      S_DIV: begin
        if (div_sts.done) begin
          rk_nxt    = TW'(div_rem);
          local_nxt = div_q;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (rd_wait_r) state_nxt = S_EMIT;
        else rd_wait_nxt = 1'b1;
      end
      S_EMIT: begin
        prev_nxt = tbl_rd_r[CW-1:0];
        if (pos_r + LW'(1) == len_r) begin
          state_nxt = S_IDLE;
        end else begin
          pos_nxt       = pos_r + LW'(1);
          state_nxt     = S_DIV;
          div_ctl.start = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // scan read waits: reset after each increment and on leaving for the base
    if (state_r == S_SCAN && rd_wait_r && len_nxt != len_r) rd_wait_nxt = 1'b0;
    if (state_r == S_SCAN && state_nxt == S_BASE) rd_wait_nxt = 1'b0;
  end

  // divider start is registered so it sees the updated local index and position
  assign div_go.start = div_go_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_wait_r   <= 1'b0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_wait_r   <= rd_wait_nxt;
      out_valid_r <= oor_nxt || (state_r == S_EMIT);
      div_go_r    <= div_ctl.start;
    end
    idx_r   <= idx_nxt;
    local_r <= local_nxt;
    len_r   <= len_nxt;
    pos_r   <= pos_nxt;
    prev_r  <= prev_nxt;
    rk_r    <= rk_nxt;
    oor_r   <= oor_nxt;
    if (oor_nxt) begin
      out_r <= '{out_char: 8'd0, char_pos: 4'd0, pass_length: 5'd0,
                 last: 1'b1, out_of_range: 1'b1};
    end else begin
      out_r.out_char     <= tbl_rd_r;
      out_r.char_pos     <= 4'(pos_r);
      out_r.pass_length  <= 5'(len_r);
      out_r.last         <= (pos_r + LW'(1) == len_r);
      out_r.out_of_range <= 1'b0;
    end
  end

  assign busy      = (state_r != S_IDLE) || out_valid_r || oor_r || div_go_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for markov_index_to_password: loads the table, radix and
// count stores, then drives directed and random generate items in phases of
// sender idling. A local predictor tracks the stores and the max length, and
// a monitor checks every character strobe against the oldest expectation.
// ----------------------------------------------------------------------------
module tb;
  import mkpw_pkg::*;

  localparam int MAXL = 16;
  localparam int NTHR = 16;
  localparam int LIMIT_CYCLES = 3000000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  mkpw_in_t  in_data;
  logic      out_valid;
  mkpw_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [4:0] cfg_data;

  markov_index_to_password dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0]  chr_tbl [MAXL][256][NTHR];
  logic [4:0]  radix_st [MAXL];
  logic [63:0] cum_st [MAXL+1];
  logic [4:0]  maxlen_reg;

  mkpw_in_t  pending_items[$];
  mkpw_out_t expected_chars[$];
  int        sender_idle_pct;
  int        mismatches;
  int        cycles;
  bit        hold_sender;

  // queue helpers
  function automatic void enqueue_item(mkpw_in_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void enqueue_expect(mkpw_out_t o);
    expected_chars.insert(expected_chars.size(), o);
  endfunction

  // password predictor
  function automatic void predict_item(mkpw_in_t it);
    int unsigned m, len, r;
    logic [63:0] loc;
    logic [7:0] pc;
    mkpw_out_t o;
    case (it.mode)
      MODE_TABLE: begin
        if (it.position < MAXL) begin
          chr_tbl[it.position][it.prev_char][it.rank] = it.value[7:0];
        end
      end
      MODE_RADIX: begin
        if (it.position < MAXL)
          radix_st[it.position] = (it.value == 0) ? 5'd1 :
                                  (it.value > NTHR) ? 5'(NTHR) : 5'(it.value);
      end
      MODE_COUNT: begin
        if (it.position <= MAXL) cum_st[it.position] = it.value;
      end
      default: begin
        m = maxlen_reg;
        if (m < 1) m = 1;
        if (m > MAXL) m = MAXL;
        if (it.value >= cum_st[m]) begin
          o = '0;
          o.last = 1;
          o.out_of_range = 1;
          enqueue_expect(o);
        end else begin
          len = 1;
          while (len < m && it.value >= cum_st[len]) len++;
          loc = it.value - cum_st[len-1];
          pc = 0;
          for (int p = 0; p < len; p++) begin
            r = 32'(loc % 64'(radix_st[p]));
            loc = loc / 64'(radix_st[p]);
            pc = chr_tbl[p][pc][r];
            o.out_char = pc;
            o.char_pos = 4'(p);
            o.pass_length = 5'(len);
            o.last = (p + 1 == len);
            o.out_of_range = 0;
            enqueue_expect(o);
          end
        end
      end
    endcase
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // driver: one transfer per start && !busy edge
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else if (start && !busy) begin
      predict_item(in_data);
      if (pending_items.size() > 0 && !hold_sender &&
          $urandom_range(99) >= sender_idle_pct) begin
        in_data <= pending_items.pop_front();
      end else begin
        start <= 0;
      end
    end else if (!start && !hold_sender && pending_items.size() > 0 &&
                 $urandom_range(99) >= sender_idle_pct) begin
      in_data <= pending_items.pop_front();
      start <= 1;
    end
  end

  // monitor: every strobe is a result transfer
  always @(posedge clk) begin
    mkpw_out_t e;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", out_data);
      end else begin
        e = expected_chars.pop_front();
        if (out_data !== e) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %p actual %p", e, out_data);
        end
      end
    end
  end

  function automatic mkpw_in_t mk(logic [1:0] md, int pos, int pc, int rk,
                                  logic [63:0] v);
    mkpw_in_t it;
    it.mode = md;
    it.position = 5'(pos);
    it.prev_char = 8'(pc);
    it.rank = 4'(rk);
    it.value = v;
    return it;
  endfunction

  // loads radixes plus table entries for a small set of rows and ranks 0 to 3,
  // keeping every generate read on written entries
  task automatic load_stores(int rows);
    for (int p = 0; p < MAXL; p++)
      enqueue_item(mk(MODE_RADIX, p, 0, 0, 64'($urandom_range(1, 4))));
    for (int p = 0; p < MAXL; p++)
      for (int c = 0; c < rows; c++)
        for (int k = 0; k < 4; k++)
          enqueue_item(mk(MODE_TABLE, p, c, k,
                          {$urandom, $urandom} % rows));
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || start) @(posedge clk);
    while (expected_chars.size() > 0) @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  task automatic write_maxlen(logic [4:0] v);
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    maxlen_reg = v;
    cfg_valid <= 0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] acc;
    mkpw_in_t it;
    int rows;
    rst_n = 0; start = 0; in_data = '0; cfg_valid = 0; cfg_data = '0;
    mismatches = 0; cycles = 0; hold_sender = 0; sender_idle_pct = 36;
    maxlen_reg = 5'd16;
    foreach (cum_st[i]) cum_st[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: radix clamps, table loads, ignored loads, counts
    rows = 4;
    enqueue_item(mk(MODE_RADIX, 0, 0, 0, 64'd0));
    enqueue_item(mk(MODE_RADIX, 1, 0, 0, '1));
    enqueue_item(mk(MODE_RADIX, 31, 0, 0, 64'd3));
    enqueue_item(mk(MODE_TABLE, 16, 5, 3, 64'hff));
    enqueue_item(mk(MODE_TABLE, 31, 255, 15, 64'h1ab));
    enqueue_item(mk(MODE_COUNT, 17, 0, 0, '1));
    load_stores(rows);
    // fixed-length top rows of unused ranks, also full-width chars
    enqueue_item(mk(MODE_TABLE, 0, 255, 15, 64'hffff_ffff_ffff_ff03));
    acc = 0;
    for (int l = 0; l <= MAXL; l++)
      enqueue_item(mk(MODE_COUNT, l, 0, 0, 64'(l * 40)));
    // empty-generate on zero count, extremes of index
    enqueue_item(mk(MODE_GEN, 0, 0, 0, 64'd0));
    enqueue_item(mk(MODE_GEN, 0, 0, 0, 64'd39));
    enqueue_item(mk(MODE_GEN, 0, 0, 0, 64'd40));
    enqueue_item(mk(MODE_GEN, 0, 0, 0, 64'd639));
    enqueue_item(mk(MODE_GEN, 0, 0, 0, 64'd640));
    enqueue_item(mk(MODE_GEN, 0, 0, 0, '1));
    wait_drained();

    // max length extremes and counts not rising (wrapping base)
    write_maxlen(5'd0);
    enqueue_item(mk(MODE_GEN, 31, 255, 15, 64'd5));
    enqueue_item(mk(MODE_GEN, 0, 0, 0, 64'd40));
    wait_drained();
    write_maxlen(5'd31);
    enqueue_item(mk(MODE_COUNT, 3, 0, 0, 64'd10));
    enqueue_item(mk(MODE_COUNT, 16, 0, 0, '1));
    enqueue_item(mk(MODE_GEN, 0, 0, 0, 64'hffff_ffff_ffff_fffe));
    enqueue_item(mk(MODE_GEN, 0, 0, 0, 64'd200));
    wait_drained();

    // random phases: sender idle 36%, 57%, then none
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 57 : 0;
      write_maxlen((ph == 2) ? 5'd16 : 5'($urandom_range(1, 16)));
      // rising counts with a random per-length step, sometimes huge
      acc = 0;
      enqueue_item(mk(MODE_COUNT, 0, 0, 0, 64'd0));
      for (int l = 1; l <= MAXL; l++) begin
        acc = acc + (($urandom_range(3) == 0) ? (rnd64() >> 5) :
                     64'($urandom_range(1, 30)));
        enqueue_item(mk(MODE_COUNT, l, 0, 0, acc));
      end
      for (int n = 0; n < 40; n++) begin
        case ($urandom_range(9))
          0: enqueue_item(mk(MODE_RADIX, $urandom_range(31), $urandom,
                             $urandom, rnd64() >> $urandom_range(63)));
          1: enqueue_item(mk(MODE_TABLE, $urandom_range(31),
                             $urandom_range(rows - 1) | ($urandom_range(1) << 7),
                             $urandom, rnd64()));
          2: enqueue_item(mk(MODE_GEN, $urandom, $urandom, $urandom,
                             rnd64()));
          default: enqueue_item(mk(MODE_GEN, $urandom, $urandom, $urandom,
                                   64'($urandom_range(0, 600))));
        endcase
        // keep rows small: characters stay below rows for generate reads
        it = pending_items[$];
        if (it.mode == MODE_TABLE && it.prev_char < rows && it.position < MAXL)
          pending_items[$].value[7:0] = 8'($urandom_range(rows - 1));
        if (it.mode == MODE_TABLE && it.rank > 3 && it.position < MAXL)
          pending_items[$].rank = 4'($urandom_range(3));
        if (it.mode == MODE_RADIX && it.position < MAXL)
          pending_items[$].value = 64'($urandom_range(0, 4)) |
                                   (($urandom_range(7) == 0) ? 64'h80 : 64'h0);
        if (it.mode == MODE_RADIX && pending_items[$].value > 4 && it.position < MAXL)
          pending_items[$].value = 64'd4;
      end
      // sender pause until all results are in
      while (pending_items.size() > 20) @(posedge clk);
      hold_sender = 1;
      while (start || expected_chars.size() > 0) @(posedge clk);
      hold_sender = 0;
      wait_drained();
    end

    if (mismatches == 0 && expected_chars.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/mkpw_pkg.sv
rtl/mkpw_div.sv
rtl/markov_index_to_password.sv
tb/tb.sv
